FILE: src/nsc_pkg.sv
package nsc_pkg;

    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned LEN_W        = 11;
    localparam int unsigned DIGIT_CNT_W  = 2;
    localparam int unsigned MAX_LINE_DEF = 1024;
    localparam int unsigned HEX_DIGITS   = 2;

    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;

    // One finished sentence
    typedef struct packed {
        logic [BYTE_W-1:0] computed_sum;
        logic [BYTE_W-1:0] received_sum;
        logic              star_found;
        logic              checksum_ok;
        logic [LEN_W-1:0]  line_length;
    } result_t;

    // Hex decode result: is_hex flag and nibble value
    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } nibble_t;

    function automatic nibble_t hex_nibble(input logic [BYTE_W-1:0] c);
        nibble_t n;
        n.is_hex = 1'b1;
        n.value  = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            n.value = c[3:0];
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            // 'A'..'F' and 'a'..'f' share the low three bits: 1..6 maps to 10..15
            n.value = {1'b1, c[2:0] + 3'd1};
        end
        else
        begin
            n.is_hex = 1'b0;
        end
        return n;
    endfunction

endpackage

FILE: src/nsc_if.sv
// Byte channel: one received character per beat
interface nsc_byte_if
    import nsc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

// Result channel: one checked sentence per beat
interface nsc_result_if
    import nsc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] computed_sum;
    logic [BYTE_W-1:0] received_sum;
    logic              star_found;
    logic              checksum_ok;
    logic [LEN_W-1:0]  line_length;

    modport source (output valid, output computed_sum, output received_sum,
                    output star_found, output checksum_ok, output line_length,
                    input ready);
    modport sink   (input valid, input computed_sum, input received_sum,
                    input star_found, input checksum_ok, input line_length,
                    output ready);
endinterface

FILE: src/nmea_sentence_checksum_check_top.sv
// The result of a sentence is registered and shows in the cycle after its newline beat.
// Throughput: one byte per cycle; the byte channel stalls only while a
// finished result waits in the output register and the sink holds ready low.
// Reset: rst_n clears the line state and the output valid at once; the block
// takes bytes as soon as reset is released.
module nmea_sentence_checksum_check_top
    import nsc_pkg::*;
#(
    parameter int unsigned MAX_LINE = MAX_LINE_DEF
)
(
    input logic                clk,
    input logic                rst_n,
    nsc_byte_if.sink           chars,
    nsc_result_if.source       sentence
);

    logic    take;
    logic    done;
    result_t result;
    logic    out_valid_reg, out_valid_next;
    result_t out_reg;

    // Accept a byte whenever the output register is free or being drained
    assign chars.ready = !out_valid_reg || sentence.ready;
    assign take        = chars.valid && chars.ready;

    nsc_line_acc #(
        .MAX_LINE (MAX_LINE)
    ) u_line_acc (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .data_byte (chars.data_byte),
        .done      (done),
        .result    (result)
    );

    // Output valid: set by a closed sentence, drop when the beat is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (done)
        begin
            out_valid_next = 1'b1;
        end
        else if (sentence.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_reg <= result;
        end
    end

    assign sentence.valid        = out_valid_reg;
    assign sentence.computed_sum = out_reg.computed_sum;
    assign sentence.received_sum = out_reg.received_sum;
    assign sentence.star_found   = out_reg.star_found;
    assign sentence.checksum_ok  = out_reg.checksum_ok;
    assign sentence.line_length  = out_reg.line_length;

endmodule

FILE: src/nsc_line_acc.sv
module nsc_line_acc
    import nsc_pkg::*;
#(
    parameter int unsigned MAX_LINE = MAX_LINE_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [BYTE_W-1:0] data_byte,
    output logic              done,
    output result_t           result
);

    localparam logic [LEN_W-1:0] LIMIT = LEN_W'(MAX_LINE);

    logic [BYTE_W-1:0]      xor_reg, xor_next;
    logic                   star_reg, star_next;
    logic [DIGIT_CNT_W-1:0] digits_reg, digits_next;
    logic                   stopped_reg, stopped_next;
    logic [BYTE_W-1:0]      rcv_reg, rcv_next;
    logic [LEN_W-1:0]       count_reg, count_next;
    nibble_t                nib;

    assign nib = hex_nibble(data_byte);

    // Sentence result from the state before the newline
    always_comb
    begin
        done                = take && (data_byte == CH_LF) && (count_reg != '0);
        result.computed_sum = xor_reg;
        result.received_sum = star_reg ? rcv_reg : '0;
        result.star_found   = star_reg;
        result.checksum_ok  = star_reg && (xor_reg == rcv_reg);
        result.line_length  = count_reg;
    end

    // Advance the line state by one byte
    always_comb
    begin
        xor_next     = xor_reg;
        star_next    = star_reg;
        digits_next  = digits_reg;
        stopped_next = stopped_reg;
        rcv_next     = rcv_reg;
        count_next   = count_reg;
        if (take && data_byte != CH_CR)
        begin
            if (data_byte == CH_LF || count_reg >= LIMIT)
            begin
                // Close the sentence or drop an overlong line
                xor_next     = '0;
                star_next    = 1'b0;
                digits_next  = '0;
                stopped_next = 1'b0;
                rcv_next     = '0;
                count_next   = '0;
            end
            else
            begin
                count_next = count_reg + LEN_W'(1);
                if (!star_reg)
                begin
                    if (data_byte == CH_STAR)
                    begin
                        star_next = 1'b1;
                    end
                    else if (data_byte != CH_DOLLAR)
                    begin
                        xor_next = xor_reg ^ data_byte;
                    end
                end
                else if (!stopped_reg && digits_reg < DIGIT_CNT_W'(HEX_DIGITS))
                begin
                    if (nib.is_hex)
                    begin
                        rcv_next    = {rcv_reg[3:0], nib.value};
                        digits_next = digits_reg + DIGIT_CNT_W'(1);
                    end
                    else
                    begin
                        stopped_next = 1'b1;
                    end
                end
            end
        end
    end

    // Hold the line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xor_reg     <= '0;
            star_reg    <= 1'b0;
            digits_reg  <= '0;
            stopped_reg <= 1'b0;
            rcv_reg     <= '0;
            count_reg   <= '0;
        end
        else
        begin
            xor_reg     <= xor_next;
            star_reg    <= star_next;
            digits_reg  <= digits_next;
            stopped_reg <= stopped_next;
            rcv_reg     <= rcv_next;
            count_reg   <= count_next;
        end
    end

endmodule

FILE: src/nsc_checker.sv
module nsc_checker
    import nsc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic [BYTE_W-1:0] in_byte,
    input logic              out_valid,
    input logic              out_ready,
    input logic [BYTE_W-1:0] computed_sum,
    input logic [BYTE_W-1:0] received_sum,
    input logic              star_found,
    input logic              checksum_ok,
    input logic [LEN_W-1:0]  line_length
);

    // A match needs the star and equal sums
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && checksum_ok |-> star_found && (computed_sum == received_sum))
        else $error("checksum_ok without star or with unequal sums");

    // A reported sentence is never empty
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> line_length != '0)
        else $error("empty sentence reported");

    // A new result only follows an accepted newline beat
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && in_byte == CH_LF))
        else $error("result without a newline");

    // A stalled result holds its valid, its sums and its length
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(computed_sum)
            && $stable(received_sum) && $stable(line_length))
        else $error("stalled result changed");

endmodule

bind nmea_sentence_checksum_check_top nsc_checker u_nsc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (chars.valid),
    .in_ready     (chars.ready),
    .in_byte      (chars.data_byte),
    .out_valid    (sentence.valid),
    .out_ready    (sentence.ready),
    .computed_sum (sentence.computed_sum),
    .received_sum (sentence.received_sum),
    .star_found   (sentence.star_found),
    .checksum_ok  (sentence.checksum_ok),
    .line_length  (sentence.line_length)
);
